// File: design/pru_pkg.sv
`default_nettype none
package pru_pkg;

  localparam int ELEMENTS = 9;
  localparam int NIB_W    = 4;
  localparam int PERM_W   = 36;
  localparam int RANK_W   = 19;
  localparam int CNT_W    = 4;
  localparam int STAGES   = ELEMENTS - 1;

  localparam logic CMD_RANK   = 1'b0;
  localparam logic CMD_UNRANK = 1'b1;

  function automatic logic [RANK_W-1:0] fact(input int n);
    logic [RANK_W-1:0] f;
    f = RANK_W'(1);
    for (int k = 2; k <= n; k++) begin
      f = RANK_W'(f * RANK_W'(k));
    end
    return f;
  endfunction

  function automatic logic [PERM_W-1:0] identity_perm();
    logic [PERM_W-1:0] p;
    p = '0;
    for (int k = 0; k < ELEMENTS; k++) begin
      p[k*NIB_W +: NIB_W] = NIB_W'(k);
    end
    return p;
  endfunction

  localparam logic [RANK_W-1:0] FACT_ELEMENTS = fact(ELEMENTS);
  localparam logic [PERM_W-1:0] IDENTITY      = identity_perm();

  // In rank beats acc is the running rank; in unrank beats it is the
  // remaining index and elem is the permutation being built.
  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [PERM_W-1:0] elem;
    logic [RANK_W-1:0] acc;
  } stage_t;

endpackage
`default_nettype wire

// File: design/pru_in_if.sv
`default_nettype none
interface pru_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [pru_pkg::PERM_W-1:0]  perm_in;
  logic [pru_pkg::RANK_W-1:0]  rank_in;

  modport source (output valid, output cmd, output perm_in, output rank_in, input ready);
  modport sink   (input valid, input cmd, input perm_in, input rank_in, output ready);
endinterface
`default_nettype wire

// File: design/pru_out_if.sv
`default_nettype none
interface pru_out_if;
  logic                        valid;
  logic                        ready;
  logic [pru_pkg::RANK_W-1:0]  rank_out;
  logic [pru_pkg::PERM_W-1:0]  perm_out;
  logic                        bad_rank;

  modport source (output valid, output rank_out, output perm_out, output bad_rank, input ready);
  modport sink   (input valid, input rank_out, input perm_out, input bad_rank, output ready);
endinterface
`default_nettype wire

// File: design/pru_stage.sv
`default_nettype none
module pru_stage #(
  parameter int POS = 0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pru_pkg::stage_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pru_pkg::stage_t      out_data
);

  localparam int N = pru_pkg::ELEMENTS - 1 - POS;
  localparam logic [pru_pkg::RANK_W-1:0] W = pru_pkg::fact(N);

  logic [pru_pkg::NIB_W-1:0]  here;
  logic [pru_pkg::NIB_W-1:0]  moved;
  logic [pru_pkg::CNT_W-1:0]  cnt;
  logic [pru_pkg::CNT_W-1:0]  digit;
  logic [pru_pkg::PERM_W-1:0] rotated;
  pru_pkg::stage_t            data_nxt;
  pru_pkg::stage_t            data_r;
  logic                       valid_r;

  always_comb begin
    here = in_data.elem[POS*pru_pkg::NIB_W +: pru_pkg::NIB_W];
    cnt  = '0;
    for (int j = POS + 1; j < pru_pkg::ELEMENTS; j++) begin
      if (in_data.elem[j*pru_pkg::NIB_W +: pru_pkg::NIB_W] < here) begin
        cnt = cnt + pru_pkg::CNT_W'(1);
      end
    end

    digit = '0;
    for (int k = 1; k <= N; k++) begin
      if (int'(in_data.acc) >= k * int'(W)) begin
        digit = digit + pru_pkg::CNT_W'(1);
      end
    end

    moved = here;
    for (int q = POS; q < pru_pkg::ELEMENTS; q++) begin
      if (q == POS + int'(digit)) begin
        moved = in_data.elem[q*pru_pkg::NIB_W +: pru_pkg::NIB_W];
      end
    end

    rotated = in_data.elem;
    rotated[POS*pru_pkg::NIB_W +: pru_pkg::NIB_W] = moved;
    for (int p = POS + 1; p < pru_pkg::ELEMENTS; p++) begin
      if (p <= POS + int'(digit)) begin
        rotated[p*pru_pkg::NIB_W +: pru_pkg::NIB_W] =
          in_data.elem[(p-1)*pru_pkg::NIB_W +: pru_pkg::NIB_W];
      end
    end

    data_nxt = in_data;
    if (in_data.cmd == pru_pkg::CMD_RANK) begin
      data_nxt.acc = pru_pkg::RANK_W'(in_data.acc +
        pru_pkg::RANK_W'({{(pru_pkg::RANK_W-pru_pkg::CNT_W){1'b0}}, cnt} * W));
    end else begin
      data_nxt.acc = pru_pkg::RANK_W'(in_data.acc -
        pru_pkg::RANK_W'({{(pru_pkg::RANK_W-pru_pkg::CNT_W){1'b0}}, digit} * W));
      data_nxt.elem = rotated;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/permutation_rank_unrank.sv
// Each accepted input beat is registered once in each stage on its way to its result beat.
// Throughput: one beat per cycle while the output is ready; each of the 8 stages resolves one position.
// A stall at the output holds each full stage whose later stages are all full; empty stages still fill.
// Reset (rst_n low, synchronous) empties the pipeline; data is not cleared.
`default_nettype none
module permutation_rank_unrank (
  input  wire logic clk,
  input  wire logic rst_n,
  pru_in_if.sink    in_ch,
  pru_out_if.source out_ch
);

  localparam int L = pru_pkg::STAGES - 1;

  logic            v   [pru_pkg::STAGES+1];
  logic            r   [pru_pkg::STAGES+1];
  pru_pkg::stage_t sd  [pru_pkg::STAGES+1];
  logic            in_bad;

  assign in_bad = (in_ch.cmd == pru_pkg::CMD_UNRANK) && (in_ch.rank_in >= pru_pkg::FACT_ELEMENTS);

  always_comb begin
    sd[0].cmd  = in_ch.cmd;
    sd[0].bad  = in_bad;
    if (in_ch.cmd == pru_pkg::CMD_RANK) begin
      sd[0].elem = in_ch.perm_in;
      sd[0].acc  = '0;
    end else begin
      sd[0].elem = pru_pkg::IDENTITY;
      sd[0].acc  = in_bad ? '0 : in_ch.rank_in;
    end
  end

  assign v[0]        = in_ch.valid;
  assign in_ch.ready = r[0];

  for (genvar g = 0; g < pru_pkg::STAGES; g++) begin : g_stage
    pru_stage #(.POS(g)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v[g]),
      .in_ready  (r[g]),
      .in_data   (sd[g]),
      .out_valid (v[g+1]),
      .out_ready (r[g+1]),
      .out_data  (sd[g+1])
    );
  end

  assign out_ch.valid            = v[pru_pkg::STAGES];
  assign r[pru_pkg::STAGES]      = out_ch.ready;
  assign out_ch.rank_out = (sd[pru_pkg::STAGES].cmd == pru_pkg::CMD_RANK) ?
                           sd[pru_pkg::STAGES].acc : '0;
  assign out_ch.perm_out = (sd[pru_pkg::STAGES].cmd == pru_pkg::CMD_UNRANK) ?
                           sd[pru_pkg::STAGES].elem : '0;
  assign out_ch.bad_rank = (sd[pru_pkg::STAGES].cmd == pru_pkg::CMD_UNRANK) &&
                           sd[pru_pkg::STAGES].bad;

  a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (sd[L+1].cmd == pru_pkg::CMD_RANK) |-> out_ch.rank_out < pru_pkg::FACT_ELEMENTS)
    else $error("rank result out of range");

  a_bad_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.bad_rank |-> out_ch.perm_out == pru_pkg::IDENTITY)
    else $error("out-of-range unrank did not give the identity permutation");

  a_first_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> v[1])
    else $error("accepted beat did not reach the first stage");

  a_rank_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (sd[L+1].cmd == pru_pkg::CMD_RANK) |-> !out_ch.bad_rank && out_ch.perm_out == '0)
    else $error("rank result carries unrank fields");

endmodule
`default_nettype wire
